// ----- design/point_segment_ccd_2d_core_defines.svh -----
// assertion helpers for the point segment collision core
`ifndef POINT_SEGMENT_CCD_2D_CORE_DEFINES_SVH
`define POINT_SEGMENT_CCD_2D_CORE_DEFINES_SVH

// same cycle implication, clocked on i_clk, off during reset
`define PSCCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication
`define PSCCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/psccd_pkg.sv -----
package psccd_pkg;

    localparam int DW         = 33;
    localparam int PW         = 2 * DW;
    localparam int CW         = PW + 2;
    localparam int LW         = 23;
    localparam int MLIMBS     = 3;
    localparam int MW         = LW * MLIMBS;
    localparam int PRW        = 2 * MW;
    localparam int DSW        = 136;
    localparam int SQW        = DSW - 2;
    localparam int SQ_STEPS   = 67;
    localparam int QW         = MW;
    localparam int TIME_FRAC  = 16;
    localparam int TW         = TIME_FRAC + 1;
    localparam int DIV_STEPS  = TIME_FRAC;
    localparam int SW         = 50;
    localparam int LENW       = 100;
    localparam int DOTW       = LENW + 1;
    localparam int NSTG       = 6 + SQ_STEPS + 1 + DIV_STEPS + 5;

    localparam logic [TW-1:0]  TIME_ONE = TW'(1) << TIME_FRAC;
    localparam logic [SQW-1:0] SQ_START = SQW'(1) << (2 * (SQ_STEPS - 1));

    typedef enum logic [1:0] {
        CFG_EPS   = 2'd0,
        CFG_ETA   = 2'd1,
        CFG_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [DW-1:0] d21x;
        logic signed [DW-1:0] d21y;
        logic signed [DW-1:0] s32x;
        logic signed [DW-1:0] s32y;
        logic signed [DW-1:0] e21x;
        logic signed [DW-1:0] e21y;
        logic signed [DW-1:0] e32x;
        logic signed [DW-1:0] e32y;
    } t_geo;

    typedef struct packed {
        t_geo          geo;
        logic          a_neg;
        logic          b_neg;
        logic          c_neg;
        logic [QW-1:0] amag;
        logic [QW-1:0] bmag;
        logic [QW-1:0] cmag;
        logic          lin;
        logic          bsmall;
        logic          dneg;
    } t_carry;

    typedef struct packed {
        logic [SQW-1:0] v;
        logic [SQW-1:0] res;
        logic [SQW-1:0] probe;
    } t_sqrt;

    typedef struct packed {
        logic [QW-1:0]        n;
        logic [QW-1:0]        d;
        logic [TIME_FRAC-1:0] q;
    } t_lane;

    typedef struct packed {
        logic ok;
        logic zn;
        logic eq;
    } t_dflag;

    typedef struct packed {
        t_geo   geo;
        t_dflag r1;
        t_dflag r2;
    } t_dcarry;

endpackage

// ----- design/psccd_mul.sv -----
module psccd_mul (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [psccd_pkg::MW-1:0]    i_a,
    input  logic [psccd_pkg::MW-1:0]    i_b,
    output logic [psccd_pkg::PRW-1:0]   o_p
);

    localparam int LW = psccd_pkg::LW;
    localparam int NL = psccd_pkg::MLIMBS;

    logic [2*LW-1:0]            r_pp [NL*NL];
    logic [psccd_pkg::PRW-1:0]  r_p;
    logic [psccd_pkg::PRW-1:0]  n_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    r_pp[i*NL+j] <= i_a[i*LW +: LW] * i_b[j*LW +: LW];
                end
            end
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
                n_p = n_p + (psccd_pkg::PRW'(r_pp[i*NL+j]) << (LW * (i + j)));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ----- design/psccd_sqrt_cell.sv -----
module psccd_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  psccd_pkg::t_sqrt   i_st,
    output psccd_pkg::t_sqrt   o_st
);

    psccd_pkg::t_sqrt              r_st;
    psccd_pkg::t_sqrt              n_st;
    logic [psccd_pkg::SQW-1:0]     trial;

    always_comb begin
        trial = i_st.res + i_st.probe;
        n_st.probe = i_st.probe >> 2;
        if (i_st.v >= trial) begin
            n_st.v   = i_st.v - trial;
            n_st.res = (i_st.res >> 1) + i_st.probe;
        end else begin
            n_st.v   = i_st.v;
            n_st.res = i_st.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

// ----- design/psccd_div_cell.sv -----
module psccd_div_cell (
    input  logic               i_clk,
    input  logic               i_en,
    input  psccd_pkg::t_lane   i_lane,
    output psccd_pkg::t_lane   o_lane
);

    psccd_pkg::t_lane             r_lane;
    psccd_pkg::t_lane             n_lane;
    logic [psccd_pkg::QW-1:0]     sh;

    always_comb begin
        sh = {i_lane.n[psccd_pkg::QW-2:0], 1'b0};
        n_lane.d = i_lane.d;
        if (sh >= i_lane.d) begin
            n_lane.n = sh - i_lane.d;
            n_lane.q = {i_lane.q[psccd_pkg::TIME_FRAC-2:0], 1'b1};
        end else begin
            n_lane.n = sh;
            n_lane.q = {i_lane.q[psccd_pkg::TIME_FRAC-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ----- design/point_segment_ccd_2d_core.sv -----
// Continuous collision test of a moving point against a moving segment over one
// unit step. One item is taken per clock while o_stall is low, and its result passes
// through the registered pipeline of coefficient multipliers, 67 square-root cells,
// 16 division cells on each of the two roots and the inside test. An output register
// with one skid entry separates the output handshake from the pipeline.
`include "point_segment_ccd_2d_core_defines.svh"

module point_segment_ccd_2d_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [31:0]  i_point_x,
    input  logic signed [31:0]  i_point_y,
    input  logic signed [31:0]  i_point_dx,
    input  logic signed [31:0]  i_point_dy,
    input  logic signed [31:0]  i_end_a_x,
    input  logic signed [31:0]  i_end_a_y,
    input  logic signed [31:0]  i_end_a_dx,
    input  logic signed [31:0]  i_end_a_dy,
    input  logic signed [31:0]  i_end_b_x,
    input  logic signed [31:0]  i_end_b_y,
    input  logic signed [31:0]  i_end_b_dx,
    input  logic signed [31:0]  i_end_b_dy,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic [16:0]         o_hit_time,
    output logic [16:0]         o_safe_step,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    localparam int DW   = psccd_pkg::DW;
    localparam int PW   = psccd_pkg::PW;
    localparam int CW   = psccd_pkg::CW;
    localparam int QW   = psccd_pkg::QW;
    localparam int TW   = psccd_pkg::TW;
    localparam int SW   = psccd_pkg::SW;
    localparam int DSW  = psccd_pkg::DSW;
    localparam int SQW  = psccd_pkg::SQW;
    localparam int LENW = psccd_pkg::LENW;
    localparam int DOTW = psccd_pkg::DOTW;
    localparam int PRW  = psccd_pkg::PRW;
    localparam int NSTG = psccd_pkg::NSTG;
    localparam int NSQ  = psccd_pkg::SQ_STEPS;
    localparam int NDV  = psccd_pkg::DIV_STEPS;
    localparam int TF   = psccd_pkg::TIME_FRAC;

    typedef struct packed {
        logic          hit;
        logic [TW-1:0] tm;
        logic [TW-1:0] step;
    } t_res;

    typedef struct packed {
        logic [TW-1:0] best;
        logic          have;
        logic          neg_rs;
        logic          neg_ry;
    } t_tail;

    // configuration
    logic [31:0]   r_eps;
    logic [TW-1:0] r_eta;
    logic [TW-1:0] r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps   <= 32'd1;
            r_eta   <= TW'(58982);
            r_limit <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psccd_pkg::CFG_EPS:   r_eps   <= i_cfg_data;
                psccd_pkg::CFG_ETA:   r_eta   <= i_cfg_data[TW-1:0];
                psccd_pkg::CFG_LIMIT: r_limit <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            en;
    logic [NSTG-1:0] r_vld;
    logic            r_out_vld;
    logic            r_skid_vld;
    t_res            r_out;
    t_res            r_skid;
    t_res            fin;

    assign en      = !r_skid_vld;
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // relative positions and displacements
    psccd_pkg::t_geo r1_geo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_geo.d21x <= DW'(i_point_x) - DW'(i_end_a_x);
            r1_geo.d21y <= DW'(i_point_y) - DW'(i_end_a_y);
            r1_geo.s32x <= DW'(i_end_b_x) - DW'(i_end_a_x);
            r1_geo.s32y <= DW'(i_end_b_y) - DW'(i_end_a_y);
            r1_geo.e21x <= DW'(i_point_dx) - DW'(i_end_a_dx);
            r1_geo.e21y <= DW'(i_point_dy) - DW'(i_end_a_dy);
            r1_geo.e32x <= DW'(i_end_b_dx) - DW'(i_end_a_dx);
            r1_geo.e32y <= DW'(i_end_b_dy) - DW'(i_end_a_dy);
        end
    end

    // cross products
    psccd_pkg::t_geo        r2_geo;
    logic signed [PW-1:0]   r2_pax, r2_pay, r2_pb1, r2_pb2, r2_pb3, r2_pb4, r2_pc1, r2_pc2;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_geo <= r1_geo;
            r2_pax <= r1_geo.e32x * r1_geo.e21y;
            r2_pay <= r1_geo.e32y * r1_geo.e21x;
            r2_pb1 <= r1_geo.e32x * r1_geo.d21y;
            r2_pb2 <= r1_geo.e32y * r1_geo.d21x;
            r2_pb3 <= r1_geo.s32x * r1_geo.e21y;
            r2_pb4 <= r1_geo.s32y * r1_geo.e21x;
            r2_pc1 <= r1_geo.s32x * r1_geo.d21y;
            r2_pc2 <= r1_geo.s32y * r1_geo.d21x;
        end
    end

    // quadratic coefficients
    psccd_pkg::t_geo        r3_geo;
    logic signed [CW-1:0]   r3_a, r3_b, r3_c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_geo <= r2_geo;
            r3_a   <= CW'(r2_pax) - CW'(r2_pay);
            r3_b   <= CW'(r2_pb1) - CW'(r2_pb2) + CW'(r2_pb3) - CW'(r2_pb4);
            r3_c   <= CW'(r2_pc1) - CW'(r2_pc2);
        end
    end

    // magnitudes, threshold tests, b*b and a*c
    logic [CW-1:0]     a_abs, b_abs, c_abs;
    logic [QW-1:0]     amag_c, bmag_c, cmag_c;
    psccd_pkg::t_carry r4_carry, r5_carry, r6_carry;
    logic [PRW-1:0]    prod_bb, prod_ac;

    always_comb begin
        a_abs  = r3_a[CW-1] ? $unsigned(-r3_a) : $unsigned(r3_a);
        b_abs  = r3_b[CW-1] ? $unsigned(-r3_b) : $unsigned(r3_b);
        c_abs  = r3_c[CW-1] ? $unsigned(-r3_c) : $unsigned(r3_c);
        amag_c = QW'(a_abs);
        bmag_c = QW'(b_abs);
        cmag_c = QW'(c_abs);
    end

    psccd_mul u_mul_bb (
        .i_clk (i_clk), .i_en (en), .i_a (bmag_c), .i_b (bmag_c), .o_p (prod_bb)
    );

    psccd_mul u_mul_ac (
        .i_clk (i_clk), .i_en (en), .i_a (amag_c), .i_b (cmag_c), .o_p (prod_ac)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_carry.geo    <= r3_geo;
            r4_carry.a_neg  <= r3_a[CW-1];
            r4_carry.b_neg  <= r3_b[CW-1];
            r4_carry.c_neg  <= r3_c[CW-1];
            r4_carry.amag   <= amag_c;
            r4_carry.bmag   <= bmag_c;
            r4_carry.cmag   <= cmag_c;
            r4_carry.lin    <= amag_c < QW'(r_eps);
            r4_carry.bsmall <= bmag_c < QW'(r_eps);
            r4_carry.dneg   <= 1'b0;
            r5_carry        <= r4_carry;
        end
    end

    // discriminant
    logic signed [DSW-1:0] bb_s, ac4, disc;
    psccd_pkg::t_carry     n6_carry;
    psccd_pkg::t_sqrt      r6_sq;

    always_comb begin
        bb_s = $signed({1'b0, prod_bb[DSW-2:0]});
        ac4  = $signed({1'b0, prod_ac[DSW-4:0], 2'b00});
        disc = (r5_carry.a_neg ^ r5_carry.c_neg) ? bb_s + ac4 : bb_s - ac4;
        n6_carry      = r5_carry;
        n6_carry.dneg = disc[DSW-1];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_carry       <= n6_carry;
            r6_sq.v        <= disc[SQW-1:0];
            r6_sq.res      <= '0;
            r6_sq.probe    <= psccd_pkg::SQ_START;
        end
    end

    // square root cells
    psccd_pkg::t_sqrt  sq_bus [NSQ+1];
    psccd_pkg::t_carry r_sqc  [NSQ];

    assign sq_bus[0] = r6_sq;

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        psccd_sqrt_cell u_cell (
            .i_clk (i_clk), .i_en (en), .i_st (sq_bus[g]), .o_st (sq_bus[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqc[0] <= r6_carry;
            for (int k = 1; k < NSQ; k++) begin
                r_sqc[k] <= r_sqc[k-1];
            end
        end
    end

    // root setup
    function automatic psccd_pkg::t_dflag ratio_flags(
        input logic [QW-1:0] n, input logic nneg, input logic [QW-1:0] d, input logic dneg
    );
        psccd_pkg::t_dflag f;
        f.zn = (n == '0);
        f.eq = (n == d);
        f.ok = (d != '0) && (f.zn || ((nneg == dneg) && (n <= d)));
        return f;
    endfunction

    function automatic logic [TW-1:0] lane_time(
        input psccd_pkg::t_dflag f, input logic [TF-1:0] q
    );
        logic [TW-1:0] t;
        if (f.zn) begin
            t = '0;
        end else if (f.eq) begin
            t = psccd_pkg::TIME_ONE;
        end else begin
            t = {1'b0, q};
        end
        return t;
    endfunction

    psccd_pkg::t_carry qc;
    logic [QW-1:0]     qm;
    logic              qneg, nohit;
    logic [QW-1:0]     n1, d1, n2, d2;
    logic              n1neg, d1neg, n2neg, d2neg;
    psccd_pkg::t_dflag f1, f2;
    psccd_pkg::t_lane  dv1_bus [NDV+1];
    psccd_pkg::t_lane  dv2_bus [NDV+1];
    psccd_pkg::t_lane  r_l1, r_l2;
    psccd_pkg::t_dcarry r_qdc;
    psccd_pkg::t_dcarry r_dvc [NDV];

    always_comb begin
        qc   = r_sqc[NSQ-1];
        qm   = qc.bmag + sq_bus[NSQ].res[QW-1:0];
        qneg = !qc.b_neg;
        if (qc.lin) begin
            n1 = qc.cmag; n1neg = !qc.c_neg; d1 = qc.bmag; d1neg = qc.b_neg;
            n2 = '0;      n2neg = 1'b0;      d2 = '0;      d2neg = 1'b0;
            nohit = qc.bsmall;
        end else begin
            n1 = qm;      n1neg = qneg;
            d1 = {qc.amag[QW-2:0], 1'b0};    d1neg = qc.a_neg;
            n2 = {qc.cmag[QW-2:0], 1'b0};    n2neg = qc.c_neg;
            d2 = qm;      d2neg = qneg;
            nohit = qc.dneg;
        end
        f1 = ratio_flags(n1, n1neg, d1, d1neg);
        f2 = ratio_flags(n2, n2neg, d2, d2neg);
        f1.ok = f1.ok && !nohit;
        f2.ok = f2.ok && !nohit && !qc.lin;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l1.n    <= n1;
            r_l1.d    <= d1;
            r_l1.q    <= '0;
            r_l2.n    <= n2;
            r_l2.d    <= d2;
            r_l2.q    <= '0;
            r_qdc.geo <= qc.geo;
            r_qdc.r1  <= f1;
            r_qdc.r2  <= f2;
        end
    end

    // division cells, one per quotient bit, two roots side by side
    assign dv1_bus[0] = r_l1;
    assign dv2_bus[0] = r_l2;

    for (genvar g = 0; g < NDV; g++) begin : g_div
        psccd_div_cell u_cell1 (
            .i_clk (i_clk), .i_en (en), .i_lane (dv1_bus[g]), .o_lane (dv1_bus[g+1])
        );
        psccd_div_cell u_cell2 (
            .i_clk (i_clk), .i_en (en), .i_lane (dv2_bus[g]), .o_lane (dv2_bus[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvc[0] <= r_qdc;
            for (int k = 1; k < NDV; k++) begin
                r_dvc[k] <= r_dvc[k-1];
            end
        end
    end

    // earliest root
    psccd_pkg::t_dcarry sc;
    logic [TW-1:0]      t1, t2, best_c;
    logic               have_c;
    logic [TW-1:0]      r_sel_best;
    logic               r_sel_have;
    psccd_pkg::t_geo    r_sel_geo;

    always_comb begin
        sc     = r_dvc[NDV-1];
        t1     = lane_time(sc.r1, dv1_bus[NDV].q);
        t2     = lane_time(sc.r2, dv2_bus[NDV].q);
        best_c = t1;
        have_c = sc.r1.ok;
        if (sc.r2.ok && (!sc.r1.ok || t2 < t1)) begin
            best_c = t2;
            have_c = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sel_best <= best_c;
            r_sel_have <= have_c;
            r_sel_geo  <= sc.geo;
        end
    end

    // moved segment and point at the hit time
    logic signed [TW:0]        best_s;
    logic signed [DW+TW:0]     m_sx, m_sy, m_rx, m_ry;
    logic signed [SW-1:0]      r_sx, r_sy, r_rx, r_ry;
    t_tail                     r_i1, r_i2, r_i3;

    always_comb begin
        best_s = $signed({1'b0, r_sel_best});
        m_sx   = r_sel_geo.e32x * best_s;
        m_sy   = r_sel_geo.e32y * best_s;
        m_rx   = r_sel_geo.e21x * best_s;
        m_ry   = r_sel_geo.e21y * best_s;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx        <= (SW'(r_sel_geo.s32x) <<< TF) + SW'(m_sx);
            r_sy        <= (SW'(r_sel_geo.s32y) <<< TF) + SW'(m_sy);
            r_rx        <= (SW'(r_sel_geo.d21x) <<< TF) + SW'(m_rx);
            r_ry        <= (SW'(r_sel_geo.d21y) <<< TF) + SW'(m_ry);
            r_i1.best   <= r_sel_best;
            r_i1.have   <= r_sel_have;
            r_i1.neg_rs <= 1'b0;
            r_i1.neg_ry <= 1'b0;
        end
    end

    // length and projection products
    logic [SW-1:0]  sx_abs, sy_abs, rx_abs, ry_abs;
    logic [QW-1:0]  sxm, sym, rxm, rym;
    logic [PRW-1:0] p_ss, p_yy, p_rs, p_ry;

    always_comb begin
        sx_abs = r_sx[SW-1] ? $unsigned(-r_sx) : $unsigned(r_sx);
        sy_abs = r_sy[SW-1] ? $unsigned(-r_sy) : $unsigned(r_sy);
        rx_abs = r_rx[SW-1] ? $unsigned(-r_rx) : $unsigned(r_rx);
        ry_abs = r_ry[SW-1] ? $unsigned(-r_ry) : $unsigned(r_ry);
        sxm    = QW'(sx_abs);
        sym    = QW'(sy_abs);
        rxm    = QW'(rx_abs);
        rym    = QW'(ry_abs);
    end

    psccd_mul u_mul_ss (.i_clk (i_clk), .i_en (en), .i_a (sxm), .i_b (sxm), .o_p (p_ss));
    psccd_mul u_mul_yy (.i_clk (i_clk), .i_en (en), .i_a (sym), .i_b (sym), .o_p (p_yy));
    psccd_mul u_mul_rs (.i_clk (i_clk), .i_en (en), .i_a (rxm), .i_b (sxm), .o_p (p_rs));
    psccd_mul u_mul_ry (.i_clk (i_clk), .i_en (en), .i_a (rym), .i_b (sym), .o_p (p_ry));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i2.best   <= r_i1.best;
            r_i2.have   <= r_i1.have;
            r_i2.neg_rs <= r_rx[SW-1] ^ r_sx[SW-1];
            r_i2.neg_ry <= r_ry[SW-1] ^ r_sy[SW-1];
            r_i3        <= r_i2;
        end
    end

    // squared length and dot product
    logic signed [DOTW-1:0] dt_rs, dt_ry;
    logic [LENW-1:0]        r_len2;
    logic signed [DOTW-1:0] r_dot;
    t_tail                  r_i4;

    always_comb begin
        dt_rs = $signed({1'b0, p_rs[LENW-1:0]});
        dt_ry = $signed({1'b0, p_ry[LENW-1:0]});
        if (r_i3.neg_rs) begin
            dt_rs = -dt_rs;
        end
        if (r_i3.neg_ry) begin
            dt_ry = -dt_ry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len2 <= p_ss[LENW-1:0] + p_yy[LENW-1:0];
            r_dot  <= dt_rs + dt_ry;
            r_i4   <= r_i3;
        end
    end

    // inside test and safe step
    logic          hit_c;
    logic [33:0]   eta_t;
    logic [17:0]   eta_sh;

    always_comb begin
        hit_c = r_i4.have && (r_len2 >= LENW'({r_eps, 32'd0})) && !r_dot[DOTW-1]
                && (r_dot[LENW-1:0] <= r_len2);
        eta_t  = r_eta * r_i4.best;
        eta_sh = eta_t[33:TF];
        fin.hit = hit_c;
        fin.tm  = hit_c ? r_i4.best : '0;
        if (!hit_c) begin
            fin.step = psccd_pkg::TIME_ONE;
        end else if (r_i4.best <= r_limit) begin
            fin.step = '0;
        end else if (eta_sh > 18'(psccd_pkg::TIME_ONE)) begin
            fin.step = psccd_pkg::TIME_ONE;
        end else begin
            fin.step = eta_sh[TW-1:0];
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (!i_stall) begin
                r_out      <= r_skid;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || !i_stall) begin
            r_out_vld <= r_vld[NSTG-1];
            r_out     <= fin;
        end else if (r_vld[NSTG-1]) begin
            r_skid_vld <= 1'b1;
            r_skid     <= fin;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_hit       = r_out.hit;
    assign o_hit_time  = r_out.tm;
    assign o_safe_step = r_out.step;

    `PSCCD_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld, "skid full with empty output")
    `PSCCD_ASSERT_NOW(a_skid_fill, $rose(r_skid_vld), $past(r_out_vld && i_stall), "bad skid fill")
    `PSCCD_ASSERT_NEXT(a_skid_drain, r_skid_vld && !i_stall, !r_skid_vld && r_out_vld, "skid not moved to output")
    `PSCCD_ASSERT_NOW(a_nohit_fields, o_valid && !o_hit, o_hit_time == '0 && o_safe_step == psccd_pkg::TIME_ONE, "miss with nonzero time or short step")

endmodule

// ----- tb/point_segment_ccd_2d_core_tb.sv -----
`timescale 1ns / 100ps

typedef logic [11:0][31:0] ccd_item_t;
typedef logic signed [159:0] wide_t;

typedef struct packed {
    logic        hit;
    logic [16:0] hit_time;
    logic [16:0] safe_step;
} ccd_result_t;

class ccd_scoreboard;
    logic [31:0] eps;
    logic [16:0] eta;
    logic [16:0] contact_lim;
    ccd_result_t expected_q[$];
    int errors;
    int checked;
    int hits;

    function new();
        eps = 32'd1;
        eta = 17'd58982;
        contact_lim = 17'd0;
        errors = 0;
        checked = 0;
        hits = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
        if (idx == psccd_pkg::CFG_EPS) begin
            eps = data;
        end else if (idx == psccd_pkg::CFG_ETA) begin
            eta = data[16:0];
        end else if (idx == psccd_pkg::CFG_LIMIT) begin
            contact_lim = data[16:0];
        end
    endfunction

    static function wide_t mag(wide_t v);
        return (v < 0) ? -v : v;
    endfunction

    // exact signed ratio in [0,1], floored to unsigned q1.16
    static function bit ratio_time(wide_t n, wide_t d, output logic [16:0] t);
        wide_t an, ad;
        logic [16:0] q;
        t = '0;
        if (d == 0) return 1'b0;
        if (n == 0) return 1'b1;
        if ((n < 0) != (d < 0)) return 1'b0;
        an = mag(n);
        ad = mag(d);
        if (an > ad) return 1'b0;
        if (an == ad) begin
            t = psccd_pkg::TIME_ONE;
            return 1'b1;
        end
        q = '0;
        for (int k = 0; k < 16; k++) begin
            an = an <<< 1;
            q = q << 1;
            if (an >= ad) begin
                an = an - ad;
                q[0] = 1'b1;
            end
        end
        t = q;
        return 1'b1;
    endfunction

    static function wide_t floor_sqrt(wide_t v_in);
        logic [159:0] v, res, probe, sum;
        v = v_in;
        res = '0;
        probe = 160'd1 << 158;
        while (probe != 0) begin
            sum = res + probe;
            if (v >= sum) begin
                v = v - sum;
                res = (res >> 1) + probe;
            end else begin
                res = res >> 1;
            end
            probe = probe >> 2;
        end
        return wide_t'(res);
    endfunction

    function bit find_contact(ccd_item_t it, output logic [16:0] t_out);
        wide_t v [12];
        wide_t d21x, d21y, s32x, s32y, e21x, e21y, e32x, e32y;
        wide_t ca, cb, cc, disc, qv, tb;
        wide_t px, py, ax, ay, bx, by, sx, sy, rx, ry, len2, dot, eps_w;
        logic [16:0] best, t1, t2;
        bit have;
        t_out = '0;
        for (int k = 0; k < 12; k++) v[k] = $signed(it[k]);
        d21x = v[0] - v[4];   d21y = v[1] - v[5];
        s32x = v[8] - v[4];   s32y = v[9] - v[5];
        e21x = v[2] - v[6];   e21y = v[3] - v[7];
        e32x = v[10] - v[6];  e32y = v[11] - v[7];
        ca = e32x * e21y - e32y * e21x;
        cb = (e32x * d21y - e32y * d21x) + (s32x * e21y - s32y * e21x);
        cc = s32x * d21y - s32y * d21x;
        eps_w = wide_t'({128'd0, eps});
        have = 1'b0;
        best = '0;
        if (mag(ca) < eps_w) begin
            if (mag(cb) < eps_w) return 1'b0;
            if (ratio_time(-cc, cb, t1)) begin
                best = t1;
                have = 1'b1;
            end
        end else begin
            disc = cb * cb - 4 * ca * cc;
            if (disc < 0) return 1'b0;
            qv = mag(cb) + floor_sqrt(disc);
            if (cb >= 0) qv = -qv;
            if (ratio_time(qv, 2 * ca, t1)) begin
                best = t1;
                have = 1'b1;
            end
            if (ratio_time(2 * cc, qv, t2)) begin
                if (!have || t2 < best) best = t2;
                have = 1'b1;
            end
        end
        if (!have) return 1'b0;
        tb = best;
        px = v[0] * 65536 + v[2] * tb;
        py = v[1] * 65536 + v[3] * tb;
        ax = v[4] * 65536 + v[6] * tb;
        ay = v[5] * 65536 + v[7] * tb;
        bx = v[8] * 65536 + v[10] * tb;
        by = v[9] * 65536 + v[11] * tb;
        sx = bx - ax;  sy = by - ay;
        rx = px - ax;  ry = py - ay;
        len2 = sx * sx + sy * sy;
        dot = rx * sx + ry * sy;
        if (len2 < (eps_w <<< 32)) return 1'b0;
        if (dot < 0) return 1'b0;
        if (dot > len2) return 1'b0;
        t_out = best;
        return 1'b1;
    endfunction

    function void note_item(ccd_item_t it);
        ccd_result_t r;
        logic [16:0] t;
        logic [33:0] prod;
        if (find_contact(it, t)) begin
            r.hit = 1'b1;
            r.hit_time = t;
            if (t <= contact_lim) begin
                r.safe_step = '0;
            end else begin
                prod = eta * t;
                r.safe_step = (prod[33:16] > psccd_pkg::TIME_ONE) ? psccd_pkg::TIME_ONE
                                                                 : prod[32:16];
            end
        end else begin
            r.hit = 1'b0;
            r.hit_time = '0;
            r.safe_step = psccd_pkg::TIME_ONE;
        end
        expected_q.push_back(r);
    endfunction

    function void check_result(ccd_result_t got);
        ccd_result_t exp_r;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result hit=%0d time=%0d step=%0d", $time,
                got.hit, got.hit_time, got.safe_step);
            errors++;
            return;
        end
        exp_r = expected_q.pop_front();
        checked++;
        if (exp_r.hit) hits++;
        if (got.hit !== exp_r.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, exp_r.hit, got.hit);
            errors++;
        end
        if (got.hit_time !== exp_r.hit_time) begin
            $display("%0t: hit_time expected %0d actual %0d", $time,
                exp_r.hit_time, got.hit_time);
            errors++;
        end
        if (got.safe_step !== exp_r.safe_step) begin
            $display("%0t: safe_step expected %0d actual %0d", $time,
                exp_r.safe_step, got.safe_step);
            errors++;
        end
    endfunction
endclass

module point_segment_ccd_2d_core_tb;

    localparam int U = 65536;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall;
    logic        o_hit;
    logic [16:0] o_hit_time;
    logic [16:0] o_safe_step;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    ccd_item_t   cur_item;

    ccd_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    int sent;
    int idle_cycles;
    int n_settings;

    point_segment_ccd_2d_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_point_x   (cur_item[0]),
        .i_point_y   (cur_item[1]),
        .i_point_dx  (cur_item[2]),
        .i_point_dy  (cur_item[3]),
        .i_end_a_x   (cur_item[4]),
        .i_end_a_y   (cur_item[5]),
        .i_end_a_dx  (cur_item[6]),
        .i_end_a_dy  (cur_item[7]),
        .i_end_b_x   (cur_item[8]),
        .i_end_b_y   (cur_item[9]),
        .i_end_b_dx  (cur_item[10]),
        .i_end_b_dy  (cur_item[11]),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_hit       (o_hit),
        .o_hit_time  (o_hit_time),
        .o_safe_step (o_safe_step),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < rx_idle_pct);
    end

    // transfer monitors and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_item(cur_item);
            if (o_valid && !i_stall) sb.check_result({o_hit, o_hit_time, o_safe_step});
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("%0t: timeout, %0d results outstanding", $time,
                        sb.expected_q.size());
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    function automatic ccd_item_t mk(int px, int py, int pdx, int pdy, int ax, int ay,
                                     int adx, int ady, int bx, int by, int bdx, int bdy);
        ccd_item_t it;
        it[0] = px;   it[1] = py;   it[2] = pdx;   it[3] = pdy;
        it[4] = ax;   it[5] = ay;   it[6] = adx;   it[7] = ady;
        it[8] = bx;   it[9] = by;   it[10] = bdx;  it[11] = bdy;
        return it;
    endfunction

    function automatic int small_coord();
        int c;
        c = int'($urandom_range(8 * U)) - 4 * U;
        if ($urandom_range(1)) c = c & ~(U / 4 - 1);
        return c;
    endfunction

    function automatic ccd_item_t rand_item();
        ccd_item_t it;
        int kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 12; k++) begin
            if (kind < 2) begin
                it[k] = $urandom;
            end else if (kind == 2) begin
                case ($urandom_range(5))
                    0: it[k] = 32'h7FFF_FFFF;
                    1: it[k] = 32'h8000_0000;
                    2: it[k] = 32'h0;
                    3: it[k] = 32'hFFFF_FFFF;
                    4: it[k] = 32'h1;
                    default: it[k] = $urandom;
                endcase
            end else begin
                it[k] = small_coord();
            end
        end
        return it;
    endfunction

    task automatic send_item(ccd_item_t it);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        cur_item = it;
        i_valid = 1'b1;
        sent++;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_directed();
        send_item(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item({12{32'h7FFF_FFFF}});
        send_item({12{32'h8000_0000}});
        send_item({6{32'h7FFF_FFFF, 32'h8000_0000}});
        // static segment on the y axis, point crossing at various times
        send_item(mk(-U, 0, 2 * U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        send_item(mk(-U, 0, U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        send_item(mk(0, 0, U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        send_item(mk(U, 0, -4 * U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        send_item(mk(-2 * U, 0, 2 * U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        send_item(mk(-U + 1, 3, 2 * U - 5, 7, 0, -U, 0, 0, 0, U, 0, 0));
        // passes beyond the segment end
        send_item(mk(-U, 2 * U, 2 * U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        // moving away
        send_item(mk(-U, 0, -U, 0, 0, -U, 0, 0, 0, U, 0, 0));
        // degenerate segment
        send_item(mk(-U, 0, 2 * U, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        // parallel motion, linear case
        send_item(mk(-U, 0, 0, U, 0, -U, 0, 0, 0, U, 0, 0));
        // everything translating together, all coefficients zero
        send_item(mk(0, 0, U, U, 0, -U, U, U, 0, U, U, U));
        // rotating segment, zero quadratic coefficient
        send_item(mk(0, U / 2, 0, 0, -U, -U, 0, 0, U, U, -2 * U, 0));
        send_item(mk(U / 4, 0, 0, 0, -U, U, 2 * U, 0, U, -U, -2 * U, 0));
        send_item(mk(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0, -U, 0, 0, 0, U, 0, 0));
    endtask

    initial begin
        logic [31:0] eps_set [4];
        logic [31:0] eta_set [4];
        logic [31:0] lim_set [4];
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        cur_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = psccd_pkg::CFG_EPS;
        i_cfg_data = '0;
        i_stall = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        sent = 0;
        idle_cycles = 0;
        n_settings = 0;
        eps_set = '{32'd1, 32'd0, 32'hFFFF_FFFF, $urandom_range(4096)};
        eta_set = '{32'd58982, 32'd65536, 32'd0, 32'hFFFE_0000 | $urandom_range(65536)};
        lim_set = '{32'd0, 32'd65536, 32'd0, $urandom_range(65536)};
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        for (int s = 0; s < 4; s++) begin
            drain();
            write_reg(psccd_pkg::CFG_EPS, eps_set[s]);
            write_reg(psccd_pkg::CFG_ETA, eta_set[s]);
            write_reg(psccd_pkg::CFG_LIMIT, lim_set[s]);
            if (s == 3) write_reg(CFG_UNUSED, $urandom);
            n_settings++;
            tx_idle_pct = 0;
            rx_idle_pct = 0;
            send_directed();
            for (int m = 0; m < 3; m++) begin
                tx_idle_pct = (m == 0) ? 25 : (m == 1) ? 73 : 0;
                rx_idle_pct = (m == 0) ? 73 : (m == 1) ? 25 : 0;
                for (int n = 0; n < 65; n++) send_item(rand_item());
            end
        end
        i_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("sent %0d items under %0d register settings, checked %0d results (%0d hits)",
            sent, n_settings, sb.checked, sb.hits);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/psccd_pkg.sv
design/psccd_mul.sv
design/psccd_sqrt_cell.sv
design/psccd_div_cell.sv
design/point_segment_ccd_2d_core.sv
tb/point_segment_ccd_2d_core_tb.sv
